// File: hdl/lfshc_pkg.sv
// Shared types and constants for the slot-cached payload header check.
// No dependencies; imported by the top level and its checker.
package lfshc_pkg;

    // Default configuration
    localparam int unsigned DEF_SLOT_COUNT     = 8;
    localparam logic [31:0] DEF_MAX_BLOCK_SIZE = 32'd2000000;

    // Field widths
    localparam int unsigned FILE_W  = 16;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned STAMP_W = 64;
    localparam int unsigned SLOT_W  = 3;
    localparam int unsigned ADDR_W  = 3;

    // Accepted header magic values
    localparam logic [31:0] MAGIC_MAIN = 32'h24E9_2764;
    localparam logic [31:0] MAGIC_TEST = 32'hFA1A_F9BF;
    localparam logic [31:0] MAGIC_REG  = 32'hAAE8_3F5F;

    // Register index of max_block_size
    localparam logic REG_MAX_BLOCK = 1'b0;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BADREQ  = 3'd1,
        ST_MAPFAIL = 3'd2,
        ST_BEYOND  = 3'd3,
        ST_MAGIC   = 3'd4,
        ST_SIZE    = 3'd5,
        ST_OVERRUN = 3'd6
    } t_status;

    // One slot entry as held in the slot memory
    typedef struct packed {
        logic [FILE_W-1:0]  file;
        logic [WORD_W-1:0]  length;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

// File: hdl/lru_file_slot_header_check.sv
// Top level of the slot-cached payload header check with its slot memory.
// Depends on lfshc_pkg.
//
// Each request names a block file and a payload position. A request with a
// negative file number or a position below 8 is answered in the cycle after
// its transfer and busy stays low. Any other request scans the slots one per
// cycle through the single read port of the slot memory, with busy high
// through the scan, update and check states; the result strobe is shown as
// busy falls, and a new request may be given in the cycle it is shown.
// The result is shown for one cycle only and must be taken then. Slot
// occupancy lives in one flip-flop per slot, cleared by reset, so no clearing
// pass is needed. max_block_size is written through the APB port at byte
// address 0 while the block is idle; the block does not enforce this.
module lru_file_slot_header_check #(
    parameter int unsigned SLOT_COUNT = lfshc_pkg::DEF_SLOT_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request
    input  logic                          start,
    output logic                          busy,
    input  logic signed [lfshc_pkg::FILE_W-1:0] i_file_number,
    input  logic [lfshc_pkg::WORD_W-1:0]  i_data_pos,
    input  logic [lfshc_pkg::WORD_W-1:0]  i_header_magic,
    input  logic [lfshc_pkg::WORD_W-1:0]  i_header_size,
    input  logic [lfshc_pkg::WORD_W-1:0]  i_file_size,
    input  logic                          i_map_ok,
    // result
    output logic                          o_strobe,
    output logic [2:0]                    o_status,
    output logic                          o_hit,
    output logic [lfshc_pkg::SLOT_W-1:0]  o_slot,
    output logic [lfshc_pkg::WORD_W-1:0]  o_payload_length,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfshc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lfshc_pkg::*;

    localparam int unsigned IW    = $clog2(SLOT_COUNT);
    localparam int unsigned CNT_W = IW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_CHECK
    } t_state;

    t_state              r_state;
    logic [WORD_W-1:0]   r_max_block;

    // captured request
    logic [FILE_W-1:0]   r_fnum;
    logic [WORD_W-1:0]   r_pos;
    logic [WORD_W-1:0]   r_magic;
    logic [WORD_W-1:0]   r_size;
    logic [WORD_W-1:0]   r_fsize;
    logic                r_mapok;

    // scan state
    logic [CNT_W-1:0]    r_rd_idx;
    logic                r_cmp_vld;
    logic [IW-1:0]       r_cmp_idx;
    logic                r_hit_found;
    logic [IW-1:0]       r_hit_idx;
    logic [WORD_W-1:0]   r_hit_len;
    logic                r_emp_found;
    logic [IW-1:0]       r_emp_idx;
    logic [IW-1:0]       r_old_idx;
    logic [STAMP_W-1:0]  r_old_stamp;

    // update results
    logic [STAMP_W-1:0]  r_counter;
    logic [WORD_W-1:0]   r_flen;
    logic [IW-1:0]       r_slot;
    logic                r_mapfail;
    logic [SLOT_COUNT-1:0] r_valid;

    // registered result
    logic                r_strobe;
    t_status             r_status;
    logic                r_hit;
    logic [IW-1:0]       r_out_slot;
    logic [WORD_W-1:0]   r_out_len;

    // slot memory
    t_entry              r_mem [SLOT_COUNT];
    t_entry              r_rd_data;

    logic                in_xfer;
    logic                bad_req;
    logic                rd_en;
    logic [IW-1:0]       victim;
    logic                map_good;
    logic                wr_en;
    t_entry              wr_data;
    logic [STAMP_W-1:0]  n_counter;
    t_status             n_status;
    logic [WORD_W:0]     end_pos;
    logic                cfg_wr;

    assign in_xfer = start && !busy;
    assign bad_req = i_file_number[FILE_W-1] || (i_data_pos < WORD_W'(8));
    assign busy    = (r_state != S_IDLE);
    assign rd_en   = (r_state == S_SCAN) && (r_rd_idx < CNT_W'(SLOT_COUNT));

    // pick the slot for a miss: first empty, else oldest stamp
    assign victim    = r_emp_found ? r_emp_idx : r_old_idx;
    assign map_good  = r_mapok && (r_fsize != '0);
    assign n_counter = r_counter + STAMP_W'(1);
    assign wr_en     = (r_state == S_UPDATE) && (r_hit_found || map_good);
    assign wr_data   = '{file: r_fnum,
                         length: r_hit_found ? r_hit_len : r_fsize,
                         stamp: n_counter};

    // header checks, in priority order
    assign end_pos = {1'b0, r_pos} + {1'b0, r_size};
    always_comb begin
        if (r_mapfail) begin
            n_status = ST_MAPFAIL;
        end else if (r_pos > r_flen) begin
            n_status = ST_BEYOND;
        end else if (r_magic != MAGIC_MAIN && r_magic != MAGIC_TEST &&
                     r_magic != MAGIC_REG) begin
            n_status = ST_MAGIC;
        end else if (r_size == '0 || r_size > r_max_block) begin
            n_status = ST_SIZE;
        end else if (end_pos > {1'b0, r_flen}) begin
            n_status = ST_OVERRUN;
        end else begin
            n_status = ST_OK;
        end
    end

    // slot memory: one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[IW-1:0]];
        end
        if (wr_en) begin
            r_mem[r_hit_found ? r_hit_idx : victim] <= wr_data;
        end
    end

    // configuration register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_BLOCK) ? r_max_block : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_block <= DEF_MAX_BLOCK_SIZE;
        end else if (cfg_wr && paddr[2] == REG_MAX_BLOCK) begin
            r_max_block <= pwdata;
        end
    end

    // sequencer: capture, scan, update, check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_strobe  <= 1'b0;
            r_valid   <= '0;
            r_counter <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_strobe  <= 1'b0;
            r_cmp_vld <= rd_en;
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_fnum      <= i_file_number;
                        r_pos       <= i_data_pos;
                        r_magic     <= i_header_magic;
                        r_size      <= i_header_size;
                        r_fsize     <= i_file_size;
                        r_mapok     <= i_map_ok;
                        r_rd_idx    <= '0;
                        r_hit_found <= 1'b0;
                        r_emp_found <= 1'b0;
                        if (bad_req) begin
                            // reject without touching any slot
                            r_strobe   <= 1'b1;
                            r_status   <= ST_BADREQ;
                            r_hit      <= 1'b0;
                            r_out_slot <= '0;
                            r_out_len  <= '0;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_rd_idx  <= r_rd_idx + CNT_W'(1);
                        r_cmp_idx <= r_rd_idx[IW-1:0];
                    end
                    if (r_cmp_vld) begin
                        if (r_valid[r_cmp_idx] && r_rd_data.file == r_fnum &&
                            !r_hit_found) begin
                            r_hit_found <= 1'b1;
                            r_hit_idx   <= r_cmp_idx;
                            r_hit_len   <= r_rd_data.length;
                        end
                        if (!r_valid[r_cmp_idx] && !r_emp_found) begin
                            r_emp_found <= 1'b1;
                            r_emp_idx   <= r_cmp_idx;
                        end
                        // oldest stamp, lowest slot wins a tie
                        if (r_cmp_idx == '0 || r_rd_data.stamp < r_old_stamp) begin
                            r_old_idx   <= r_cmp_idx;
                            r_old_stamp <= r_rd_data.stamp;
                        end
                        if (r_cmp_idx == IW'(SLOT_COUNT - 1)) begin
                            r_state <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE: begin
                    r_mapfail <= 1'b0;
                    if (r_hit_found) begin
                        r_slot    <= r_hit_idx;
                        r_flen    <= r_hit_len;
                        r_counter <= n_counter;
                    end else begin
                        r_slot <= victim;
                        r_flen <= r_fsize;
                        if (map_good) begin
                            r_valid[victim] <= 1'b1;
                            r_counter       <= n_counter;
                        end else begin
                            r_valid[victim] <= 1'b0;
                            r_mapfail       <= 1'b1;
                        end
                    end
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_strobe   <= 1'b1;
                    r_status   <= n_status;
                    r_hit      <= r_hit_found;
                    r_out_slot <= r_slot;
                    r_out_len  <= (n_status == ST_OK) ? r_size : '0;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_hit            = r_hit;
    assign o_slot           = SLOT_W'(r_out_slot);
    assign o_payload_length = r_out_len;

endmodule

// File: hdl/lfshc_checker.sv
// Port-level checks for the slot-cached payload header check, and the bind
// that attaches them to the top level. Depends on lfshc_pkg.
module lfshc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic signed [lfshc_pkg::FILE_W-1:0] i_file_number,
    input  logic [lfshc_pkg::WORD_W-1:0]  i_data_pos,
    input  logic                          o_strobe,
    input  logic [2:0]                    o_status,
    input  logic                          o_hit,
    input  logic [lfshc_pkg::SLOT_W-1:0]  o_slot,
    input  logic [lfshc_pkg::WORD_W-1:0]  o_payload_length
);
    import lfshc_pkg::*;

    logic in_bad;
    assign in_bad = i_file_number[FILE_W-1] || (i_data_pos < WORD_W'(8));

    // reject a bad request in the next cycle, on slot zero
    a_bad_req_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && in_bad |=> o_strobe && o_status == ST_BADREQ && o_slot == '0)
        else $error("bad request not answered next cycle");

    // a good request occupies the block
    a_good_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !in_bad |=> busy && !o_strobe)
        else $error("good request did not raise busy");

    // only a passing result carries a length
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status != ST_OK |-> o_payload_length == '0)
        else $error("failing result with non-zero length");

    // a rejected or unmapped request never reports a hit
    a_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == ST_BADREQ || o_status == ST_MAPFAIL) |-> !o_hit)
        else $error("hit reported on rejected or unmapped request");

endmodule

bind lru_file_slot_header_check lfshc_checker u_lfshc_checker (.*);
